[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks, compiled out for synthesis
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`endif

`endif

[hw/rtl/ile_pkg.sv]
`timescale 1ns / 1ps

package ile_pkg;

  localparam int ILE_CAPACITY = 16;

  localparam int KIND_W      = 3;
  localparam int POS_W       = 4;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_POS_W   = 4;
  localparam int OUT_COUNT_W = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] K_GET    = 3'd1;
  localparam logic [KIND_W-1:0] K_SET    = 3'd2;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] K_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // memory write port source
  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_APPEND = 2'd1;
  localparam logic [1:0] WR_SET    = 2'd2;
  localparam logic [1:0] WR_SHIFT  = 2'd3;

  // pointer load source
  localparam logic [1:0] PTR_ZERO = 2'd0;
  localparam logic [1:0] PTR_POS  = 2'd1;
  localparam logic [1:0] PTR_POS1 = 2'd2;

  typedef struct packed {
    logic                capture;
    logic [1:0]          wr_sel;
    logic                count_inc;
    logic                count_dec;
    logic                ptr_load;
    logic [1:0]          ptr_src;
    logic                rd_issue;
    logic                st_load;
    logic [STATUS_W-1:0] st_val;
    logic                load_read_word;
    logic                load_found;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_range;
    logic              full;
    logic              ptr_lt_count;
    logic              match;
    logic              out_free;
  } sts_t;

endpackage

[hw/rtl/ile_ctrl.sv]
`timescale 1ns / 1ps

module ile_ctrl import ile_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_GET_RD = 3'd2;
  localparam logic [2:0] S_GET_WT = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= cmd.rd_issue;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (sts.kind)
          K_APPEND: begin
            if (sts.full) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_FULL;
            end else begin
              cmd.wr_sel    = WR_APPEND;
              cmd.count_inc = 1'b1;
            end
          end
          K_GET: begin
            if (!sts.in_range) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_RANGE;
            end else begin
              cmd.ptr_load = 1'b1;
              cmd.ptr_src  = PTR_POS;
              state_next   = S_GET_RD;
            end
          end
          K_SET: begin
            if (!sts.in_range) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_RANGE;
            end else begin
              cmd.wr_sel = WR_SET;
            end
          end
          K_REMOVE: begin
            if (!sts.in_range) begin
              cmd.st_load = 1'b1;
              cmd.st_val  = ST_RANGE;
            end else begin
              cmd.ptr_load = 1'b1;
              cmd.ptr_src  = PTR_POS1;
              state_next   = S_REM;
            end
          end
          K_SEARCH: begin
            cmd.ptr_load = 1'b1;
            cmd.ptr_src  = PTR_ZERO;
            state_next   = S_SRCH;
          end
          default: begin
          end
        endcase
      end
      S_GET_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_GET_WT;
      end
      S_GET_WT: begin
        cmd.load_read_word = 1'b1;
        state_next         = S_FINISH;
      end
      S_REM: begin
        // read one entry ahead, write it one slot lower in the following cycle
        if (pend) begin
          cmd.wr_sel = WR_SHIFT;
        end
        if (sts.ptr_lt_count) begin
          cmd.rd_issue = 1'b1;
        end
        if (!pend && !sts.ptr_lt_count) begin
          cmd.count_dec = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_SRCH: begin
        if (pend && sts.match) begin
          cmd.load_found = 1'b1;
          state_next     = S_FINISH;
        end else begin
          if (sts.ptr_lt_count) begin
            cmd.rd_issue = 1'b1;
          end
          if (!pend && !sts.ptr_lt_count) begin
            cmd.st_load = 1'b1;
            cmd.st_val  = ST_NOTFOUND;
            state_next  = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/ile_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ile_dp import ile_pkg::*; #(
  parameter int CAPACITY = ILE_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WORD_W-1:0]      cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0]    mem [CAPACITY];
  logic [WORD_W-1:0]    rdata;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic [WORD_W-1:0]    mask;

  logic [KIND_W-1:0]    req_kind;
  logic [POS_W-1:0]     req_pos;
  logic [WORD_W-1:0]    req_word;

  logic [STATUS_W-1:0]  res_status;
  logic [WORD_W-1:0]    res_read_word;
  logic [OUT_POS_W-1:0] res_found;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [WORD_W-1:0]    out_read_word;
  logic [OUT_POS_W-1:0] out_found;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                 out_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '1;
    end else if (cfg_valid) begin
      mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind      <= s_tuser;
      req_pos       <= s_tdata[POS_W-1:0];
      req_word      <= s_tdata[POS_W +: WORD_W];
      res_status    <= ST_OK;
      res_read_word <= '0;
      res_found     <= '0;
    end else begin
      if (cmd.st_load) begin
        res_status <= cmd.st_val;
      end
      if (cmd.load_read_word) begin
        res_read_word <= rdata;
      end
      if (cmd.load_found) begin
        res_found <= OUT_POS_W'(rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_load) begin
      case (cmd.ptr_src)
        PTR_POS:  ptr <= CW'(req_pos);
        PTR_POS1: ptr <= CW'(req_pos) + CW'(1);
        default:  ptr <= '0;
      endcase
    end else if (cmd.rd_issue) begin
      ptr <= ptr + CW'(1);
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    case (cmd.wr_sel)
      WR_APPEND: mem[count[AW-1:0]] <= req_word;
      WR_SET:    mem[AW'(req_pos)] <= req_word;
      WR_SHIFT:  mem[rd_addr - AW'(1)] <= rdata;
      default: begin
      end
    endcase
    if (cmd.rd_issue) begin
      rdata   <= mem[ptr[AW-1:0]];
      rd_addr <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status    <= res_status;
      out_read_word <= res_read_word;
      out_found     <= res_found;
      out_count     <= OUT_COUNT_W'(count);
      out_empty     <= (count == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_empty, out_count, out_found, out_read_word, out_status};

  assign sts.kind         = req_kind;
  assign sts.in_range     = (MW'(req_pos) < MW'(count));
  assign sts.full         = (count == CW'(CAPACITY));
  assign sts.ptr_lt_count = (ptr < count);
  assign sts.match        = (((rdata ^ req_word) & mask) == '0);
  assign sts.out_free     = !out_valid || m_tready;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(CAPACITY))
  `ASSERT_IMPLIES(a_inc_not_full, clk, rst, cmd.count_inc, count != CW'(CAPACITY))
  `ASSERT_IMPLIES(a_dec_not_empty, clk, rst, cmd.count_dec, count != '0)
  `ASSERT_IMPLIES(a_load_out_free, clk, rst, cmd.load_out, !out_valid || m_tready)

endmodule

[hw/rtl/indexed_list_engine.sv]
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// s        in   s_tvalid / s_tready       s_tdata {word, position}, s_tuser kind
// m        out  m_tvalid / m_tready       m_tdata {is_empty, count, found_position,
//                                                  read_word, status}
// cfg      in   cfg_valid / cfg_ready     cfg_data match_mask
//
// one request at a time: accept, decode, then a read for get, a shift of the later
// entries for remove or a scan from index 0 for search, then result load;
// append, set, unknown kinds and refused requests go straight from decode to
// result load; search stops at the first match or at the end of the list
// rst (synchronous) empties the list and sets match_mask to all ones
// a waiting result blocks nothing; a stalled output only holds the last step

module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = ILE_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // position[3:0], word[35:4], zero pad
  input  logic [KIND_W-1:0]      s_tuser,   // kind[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], read_word[33:2],
                                            // found_position[37:34], count[42:38],
                                            // is_empty[43], zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WORD_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ile_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[bench/list_result_checker.sv]
`timescale 1ns / 1ps

module list_result_checker import ile_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // position[3:0], word[35:4], zero pad
  input  logic [KIND_W-1:0]      s_tuser,   // kind[2:0]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // status, read_word, found_position,
                                            // count, is_empty, zero pad
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [WORD_W-1:0]      cfg_data,
  output int                     fail_count,
  output int                     outstanding,
  output int                     results_checked,
  output logic [OUT_COUNT_W-1:0] list_len
);

  localparam int RD_LSB    = STATUS_W;
  localparam int FOUND_LSB = RD_LSB + WORD_W;
  localparam int COUNT_LSB = FOUND_LSB + OUT_POS_W;
  localparam int EMPTY_BIT = COUNT_LSB + OUT_COUNT_W;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [WORD_W-1:0]      read_word;
    logic [OUT_POS_W-1:0]   found_position;
    logic [OUT_COUNT_W-1:0] count;
    logic                   is_empty;
  } list_result_t;

  logic [WORD_W-1:0] list_words [ILE_CAPACITY];
  logic [WORD_W-1:0] search_mask;
  list_result_t      expected_results [$];

  // applies one request to the shadow list and returns what the block must answer
  function automatic list_result_t serve_request(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [WORD_W-1:0] word);
    list_result_t res;
    logic         in_range;
    logic         hit;
    int           i;
    res = '0;
    res.status = ST_OK;
    in_range = int'(pos) < int'(list_len);
    hit = 1'b0;
    case (kind)
      K_APPEND: begin
        if (int'(list_len) >= ILE_CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len[POS_W-1:0]] = word;
          list_len = list_len + OUT_COUNT_W'(1);
        end
      end
      K_GET: begin
        if (in_range) res.read_word = list_words[pos];
        else res.status = ST_RANGE;
      end
      K_SET: begin
        if (in_range) list_words[pos] = word;
        else res.status = ST_RANGE;
      end
      K_REMOVE: begin
        if (in_range) begin
          // close the gap, later words move down by one
          for (i = int'(pos); i + 1 < int'(list_len); i++) list_words[i] = list_words[i + 1];
          list_len = list_len - OUT_COUNT_W'(1);
        end else begin
          res.status = ST_RANGE;
        end
      end
      K_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < int'(list_len); i++) begin
          if (!hit && ((list_words[i] ^ word) & search_mask) == '0) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.found_position = i[OUT_POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    res.count = list_len;
    res.is_empty = (list_len == '0);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("result %0d: %s expected %0h got %0h", results_checked, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      list_len = '0;
      search_mask = '1;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, m_tdata[WORD_W-1:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[STATUS_W-1:0] !== want.status)
            report_mismatch("status", WORD_W'(want.status), WORD_W'(m_tdata[STATUS_W-1:0]));
          if (m_tdata[RD_LSB +: WORD_W] !== want.read_word)
            report_mismatch("read_word", want.read_word, m_tdata[RD_LSB +: WORD_W]);
          if (m_tdata[FOUND_LSB +: OUT_POS_W] !== want.found_position)
            report_mismatch("found_position", WORD_W'(want.found_position),
                            WORD_W'(m_tdata[FOUND_LSB +: OUT_POS_W]));
          if (m_tdata[COUNT_LSB +: OUT_COUNT_W] !== want.count)
            report_mismatch("count", WORD_W'(want.count),
                            WORD_W'(m_tdata[COUNT_LSB +: OUT_COUNT_W]));
          if (m_tdata[EMPTY_BIT] !== want.is_empty)
            report_mismatch("is_empty", WORD_W'(want.is_empty), WORD_W'(m_tdata[EMPTY_BIT]));
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) search_mask = cfg_data;
      if (s_tvalid && s_tready)
        expected_results.push_back(serve_request(s_tuser, s_tdata[POS_W-1:0],
                                                 s_tdata[POS_W +: WORD_W]));
      outstanding <= expected_results.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ile_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // position[3:0], word[35:4], zero pad
  logic [KIND_W-1:0]      s_tuser;   // kind[2:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;   // status, read_word, found_position, count,
                                     // is_empty, zero pad
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [WORD_W-1:0]      cfg_data;

  int                     fail_count;
  int                     outstanding;
  int                     results_checked;
  logic [OUT_COUNT_W-1:0] list_len;

  int                cycle_count = 0;
  int                requests_sent = 0;
  int                masks_written = 0;
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;
  logic [7:0]        rx_tick = '0;
  logic              growing = 1'b1;
  int                flip_left = 40;
  logic [WORD_W-1:0] current_mask = '1;
  logic [WORD_W-1:0] word_pool [8];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  indexed_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  list_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .list_len        (list_len)
  );

  // receiver: switches at random between four stall patterns
  always @(negedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_tick[1:0] != 2'b11);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("tb_top failed");
      $finish;
    end
  end

  // one request, with the sender's burst and gap pattern applied before it
  task automatic issue(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                       logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_W'($urandom_range(0, 7));
        s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_TDATA_W - WORD_W - POS_W){1'b0}}, word, pos};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  task automatic write_mask(logic [WORD_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    current_mask = value;
    masks_written++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_request();
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int                r;
    int                grow_w;
    int                shrink_w;
    grow_w   = growing ? 45 : 10;
    shrink_w = growing ? 10 : 40;
    r = $urandom_range(0, 99);
    if (r < grow_w) kind = K_APPEND;
    else if (r < grow_w + shrink_w) kind = K_REMOVE;
    else if (r < grow_w + shrink_w + 15) kind = K_GET;
    else if (r < grow_w + shrink_w + 27) kind = K_SET;
    else if (r < 96) kind = K_SEARCH;
    else kind = KIND_W'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST));
    // mostly valid indices, some past the end
    if (list_len != '0 && $urandom_range(0, 4) != 0)
      pos = POS_W'($urandom_range(0, list_len - 1));
    else pos = POS_W'($urandom_range(0, 15));
    word = pick_word();
    // search keys that differ from a stored word only in bits the mask ignores
    if (kind == K_SEARCH && $urandom_range(0, 1) == 1)
      word = word_pool[$urandom_range(0, 7)] ^ ($urandom & ~current_mask);
    issue(kind, pos, word);
    flip_left--;
    if (flip_left == 0) begin
      growing = !growing;
      flip_left = $urandom_range(20, 80);
    end
  endtask

  initial begin
    logic [WORD_W-1:0] mask_plan [PHASES];
    logic [WORD_W-1:0] w;
    int                i;
    int                p;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = K_APPEND;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    mask_plan[0] = 32'h0000_0000;
    mask_plan[1] = 32'h0000_FFFF;
    mask_plan[2] = 32'hFFFF_0000;
    mask_plan[3] = $urandom;
    mask_plan[4] = 32'h8000_0001;
    mask_plan[5] = 32'hFFFF_FFFF;
    for (i = 0; i < 8; i++) word_pool[i] = $urandom;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // empty list: every indexed request is out of range, search finds nothing
    issue(K_GET, 4'd0, '0);
    issue(K_SET, 4'd15, 32'h1234_5678);
    issue(K_REMOVE, 4'd0, '0);
    issue(K_SEARCH, 4'd0, '0);
    issue(K_SPARE_FIRST, 4'd15, '1);
    issue(K_SPARE_LAST, 4'd0, '0);
    // fill to capacity with a repeated all-ones word, then one append too many
    for (i = 0; i < ILE_CAPACITY; i++) begin
      if (i == 0) w = '0;
      else if (i == 1 || i == 10) w = '1;
      else w = $urandom;
      issue(K_APPEND, i[POS_W-1:0], w);
    end
    issue(K_APPEND, 4'd0, 32'h5A5A_0F0F);
    issue(K_GET, 4'd15, '0);
    issue(K_GET, 4'd0, '0);
    issue(K_SEARCH, 4'd0, '1);
    issue(K_SET, 4'd15, 32'hA5A5_A5A5);
    issue(K_SEARCH, 4'd0, 32'hA5A5_A5A5);
    issue(K_REMOVE, 4'd0, '0);
    issue(K_REMOVE, 4'd14, '0);
    issue(K_GET, 4'd15, '0);

    for (p = 0; p < PHASES; p++) begin
      write_mask(mask_plan[p]);
      for (i = 0; i < 8; i++)
        word_pool[i] = i[0] ? {word_pool[0][31:16], 16'($urandom)} : $urandom;
      for (i = 0; i < ITEMS_PER_PHASE; i++) random_request();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    $display("summary: %0d requests of all kinds under %0d match masks, %0d results compared",
             requests_sent, masks_written + 1, results_checked);
    $display("mask settings ranged from zero to all ones, list lengths from empty to full");
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[indexed_list_engine.f]
+incdir+hw/rtl
hw/rtl/ile_pkg.sv
hw/rtl/ile_ctrl.sv
hw/rtl/ile_dp.sv
hw/rtl/indexed_list_engine.sv
bench/list_result_checker.sv
bench/tb_top.sv
